// File: rtl/hrke_pkg.sv
`timescale 1ns / 1ps

package hrke_pkg;

   localparam int SLOT_COUNT  = 6;
   localparam int MOD_BITS    = 8;
   localparam int MAP_DEPTH   = 264;
   localparam int MOD_BASE    = 256;
   localparam int COUNT_DEPTH = 256;
   localparam logic [7:0] COUNT_MAX = 8'hFF;

   // sequencer steps: modifiers, then releases, then presses
   localparam logic [4:0] REL_FIRST   = 5'd8;
   localparam logic [4:0] PRESS_FIRST = 5'd14;
   localparam logic [4:0] STEP_LAST   = 5'd19;

   localparam logic [1:0] CMD_REPORT    = 2'd0;
   localparam logic [1:0] CMD_MAP_WRITE = 2'd1;
   localparam logic [1:0] CMD_RECONNECT = 2'd2;

   typedef logic [SLOT_COUNT-1:0][7:0] key_set_type;

   typedef struct packed {
      logic [1:0] command;
      logic [7:0] modifier_bits;
      logic [7:0] key_slot_0;
      logic [7:0] key_slot_1;
      logic [7:0] key_slot_2;
      logic [7:0] key_slot_3;
      logic [7:0] key_slot_4;
      logic [7:0] key_slot_5;
      logic [8:0] map_index;
      logic [7:0] map_code;
   } req_type;

   typedef struct packed {
      logic       pressed;
      logic [7:0] key_code;
      logic       last;
   } rsp_type;

   typedef struct packed {
      logic       pressed;
      logic [7:0] key_code;
   } event_type;

   typedef struct packed {
      logic      push;
      logic      flush;
      event_type evt;
   } evq_ctl_type;

   function automatic logic holds_usage(input key_set_type set, input logic [7:0] usage);
      logic hit;
      hit = 1'b0;
      for (int i = 0; i < SLOT_COUNT; i++) begin
         if (set[i] == usage) begin
            hit = 1'b1;
         end
      end
      return hit;
   endfunction

endpackage

// File: rtl/hid_report_to_key_events_core.sv
`timescale 1ns / 1ps

// Turns USB HID boot keyboard reports into key press and release transactions.
// After reset a clearing pass zeroes the key map and the press counts; no
// request is taken during it. A map write or reconnect request is handled
// in the idle state. A report walks 20 steps (8 modifier bits, 6 release
// slots, 6 press slots) through the map memory and the count memory, then a
// flush state; rsp_stall can hold the walk back while the event register is
// full. Events leave in report order; the last event of a report carries last.
module hid_report_to_key_events_core import hrke_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_payload,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_payload
);

   typedef enum logic [5:0] {
      ST_CLEAR = 6'b000001,
      ST_IDLE  = 6'b000010,
      ST_MAP   = 6'b000100,
      ST_CODE  = 6'b001000,
      ST_COUNT = 6'b010000,
      ST_FLUSH = 6'b100000
   } state_type;

   state_type   state_ff, state_in;
   logic [8:0]  clr_ff, clr_in;
   logic [4:0]  step_ff, step_in;
   logic [7:0]  prev_mods_ff, prev_mods_in;
   key_set_type prev_keys_ff, prev_keys_in;
   logic [7:0]  cur_mods_ff, cur_mods_in;
   key_set_type cur_keys_ff, cur_keys_in;
   logic        press_ff, press_in;
   logic [7:0]  code_ff, code_in;

   // memories
   logic [7:0]  key_map_mem [MAP_DEPTH];
   logic [7:0]  count_mem [COUNT_DEPTH];
   logic [7:0]  map_q_ff;
   logic [7:0]  cnt_q_ff;
   logic        map_we, map_re, cnt_we, cnt_re;
   logic [8:0]  map_wa, map_ra;
   logic [7:0]  map_wd, cnt_wa, cnt_ra, cnt_wd;

   logic        accept;
   logic        step_need, step_press;
   logic [8:0]  step_addr;
   logic [4:0]  rel_off, press_off;
   logic [2:0]  rel_j, press_j;
   logic [7:0]  rel_u, press_u;
   logic        mod_was, mod_now;
   logic [7:0]  cnt_next;
   logic        emit;
   evq_ctl_type evq_ctl;
   logic        evq_room;

   assign accept    = req_valid && !req_stall;
   assign req_stall = (state_ff != ST_IDLE);

   // what the current step looks at
   assign rel_off   = step_ff - REL_FIRST;
   assign press_off = step_ff - PRESS_FIRST;
   assign rel_j     = rel_off[2:0];
   assign press_j   = press_off[2:0];
   assign rel_u     = prev_keys_ff[rel_j];
   assign press_u   = cur_keys_ff[press_j];
   assign mod_was   = prev_mods_ff[step_ff[2:0]];
   assign mod_now   = cur_mods_ff[step_ff[2:0]];

   always_comb begin
      if (step_ff < REL_FIRST) begin
         step_need  = (mod_was != mod_now);
         step_press = mod_now;
         step_addr  = 9'(MOD_BASE) + {6'd0, step_ff[2:0]};
      end else if (step_ff < PRESS_FIRST) begin
         // release of a previous usage that left the report
         step_need  = (rel_u != 8'd0) && !holds_usage(cur_keys_ff, rel_u);
         step_press = 1'b0;
         step_addr  = {1'b0, rel_u};
      end else begin
         // press of a new usage that was not held before
         step_need  = (press_u != 8'd0) && !holds_usage(prev_keys_ff, press_u);
         step_press = 1'b1;
         step_addr  = {1'b0, press_u};
      end
   end

   // count update: press saturates, release stops at zero
   always_comb begin
      if (press_ff) begin
         emit     = (cnt_q_ff == 8'd0);
         cnt_next = (cnt_q_ff == COUNT_MAX) ? cnt_q_ff : cnt_q_ff + 8'd1;
      end else begin
         cnt_next = (cnt_q_ff == 8'd0) ? 8'd0 : cnt_q_ff - 8'd1;
         emit     = (cnt_q_ff == 8'd1);
      end
   end

   always_comb begin
      state_in     = state_ff;
      clr_in       = clr_ff;
      step_in      = step_ff;
      prev_mods_in = prev_mods_ff;
      prev_keys_in = prev_keys_ff;
      cur_mods_in  = cur_mods_ff;
      cur_keys_in  = cur_keys_ff;
      press_in     = press_ff;
      code_in      = code_ff;
      map_we       = 1'b0;
      map_wa       = clr_ff;
      map_wd       = 8'd0;
      map_re       = 1'b0;
      map_ra       = step_addr;
      cnt_we       = 1'b0;
      cnt_wa       = code_ff;
      cnt_wd       = cnt_next;
      cnt_re       = 1'b0;
      cnt_ra       = map_q_ff;
      evq_ctl.push = 1'b0;
      evq_ctl.flush = 1'b0;
      evq_ctl.evt.pressed  = press_ff;
      evq_ctl.evt.key_code = code_ff;

      case (state_ff)
         ST_CLEAR: begin
            // zero both memories, one entry a cycle
            map_we = 1'b1;
            if (clr_ff < 9'(COUNT_DEPTH)) begin
               cnt_we = 1'b1;
               cnt_wa = clr_ff[7:0];
               cnt_wd = 8'd0;
            end
            if (clr_ff == 9'(MAP_DEPTH - 1)) begin
               state_in = ST_IDLE;
            end else begin
               clr_in = clr_ff + 9'd1;
            end
         end
         ST_IDLE: begin
            if (accept) begin
               case (req_payload.command)
                  CMD_REPORT: begin
                     cur_mods_in = req_payload.modifier_bits;
                     cur_keys_in = {req_payload.key_slot_5, req_payload.key_slot_4,
                                    req_payload.key_slot_3, req_payload.key_slot_2,
                                    req_payload.key_slot_1, req_payload.key_slot_0};
                     step_in  = 5'd0;
                     state_in = ST_MAP;
                  end
                  CMD_MAP_WRITE: begin
                     if (req_payload.map_index < 9'(MAP_DEPTH)) begin
                        map_we = 1'b1;
                        map_wa = req_payload.map_index;
                        map_wd = req_payload.map_code;
                     end
                  end
                  CMD_RECONNECT: begin
                     prev_mods_in = 8'd0;
                     prev_keys_in = '0;
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_MAP: begin
            press_in = step_press;
            if (step_need) begin
               map_re   = 1'b1;
               state_in = ST_CODE;
            end else if (step_ff == STEP_LAST) begin
               state_in = ST_FLUSH;
            end else begin
               step_in = step_ff + 5'd1;
            end
         end
         ST_CODE: begin
            // translated code of zero is ignored
            code_in = map_q_ff;
            if (map_q_ff != 8'd0) begin
               cnt_re   = 1'b1;
               state_in = ST_COUNT;
            end else if (step_ff == STEP_LAST) begin
               state_in = ST_FLUSH;
            end else begin
               step_in  = step_ff + 5'd1;
               state_in = ST_MAP;
            end
         end
         ST_COUNT: begin
            // wait for event room before committing the write back
            if (!emit || evq_room) begin
               cnt_we       = 1'b1;
               evq_ctl.push = emit;
               if (step_ff == STEP_LAST) begin
                  state_in = ST_FLUSH;
               end else begin
                  step_in  = step_ff + 5'd1;
                  state_in = ST_MAP;
               end
            end
         end
         ST_FLUSH: begin
            evq_ctl.flush = 1'b1;
            if (evq_room) begin
               prev_mods_in = cur_mods_ff;
               prev_keys_in = cur_keys_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= 9'd0;
         step_ff      <= 5'd0;
         prev_mods_ff <= 8'd0;
         prev_keys_ff <= '0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         step_ff      <= step_in;
         prev_mods_ff <= prev_mods_in;
         prev_keys_ff <= prev_keys_in;
      end
      cur_mods_ff <= cur_mods_in;
      cur_keys_ff <= cur_keys_in;
      press_ff    <= press_in;
      code_ff     <= code_in;
   end

   // key map memory, read data held until the next read
   always_ff @(posedge clock) begin
      if (map_we) begin
         key_map_mem[map_wa] <= map_wd;
      end
      if (map_re) begin
         map_q_ff <= key_map_mem[map_ra];
      end
   end

   // press count memory
   always_ff @(posedge clock) begin
      if (cnt_we) begin
         count_mem[cnt_wa] <= cnt_wd;
      end
      if (cnt_re) begin
         cnt_q_ff <= count_mem[cnt_ra];
      end
   end

   hrke_out_stage u_out_stage (
      .clock       (clock),
      .reset       (reset),
      .ctl         (evq_ctl),
      .room        (evq_room),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

   // ignored codes never reach the output
   a_code_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_payload.key_code != 8'd0)
      else $error("event with key code zero");

   // the held event is never overwritten
   a_push_room: assert property (@(posedge clock) disable iff (reset)
      evq_ctl.push |-> evq_room)
      else $error("event pushed without room");

   // an accepted report starts the step walk at its first step
   a_report_start: assert property (@(posedge clock) disable iff (reset)
      accept && req_payload.command == CMD_REPORT |=> state_ff == ST_MAP && step_ff == 5'd0)
      else $error("report did not start the step walk");

   a_step_range: assert property (@(posedge clock) disable iff (reset)
      step_ff <= STEP_LAST)
      else $error("step counter out of range");

endmodule

// File: rtl/hrke_out_stage.sv
`timescale 1ns / 1ps

// holds one event back so the final event of a report can be tagged last
module hrke_out_stage import hrke_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  evq_ctl_type ctl,
   output logic        room,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output rsp_type     rsp_payload
);

   logic      pend_v_ff, pend_v_in;
   event_type pend_ff, pend_in;
   logic      rsp_valid_ff, rsp_valid_in;
   rsp_type   rsp_ff, rsp_in;
   logic      out_free;
   logic      load_out;

   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign room     = !pend_v_ff || out_free;
   assign load_out = room && pend_v_ff && (ctl.push || ctl.flush);

   always_comb begin
      pend_v_in    = pend_v_ff;
      pend_in      = pend_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      if (load_out) begin
         rsp_valid_in     = 1'b1;
         rsp_in.pressed   = pend_ff.pressed;
         rsp_in.key_code  = pend_ff.key_code;
         rsp_in.last      = ctl.flush;
      end
      if (ctl.push && room) begin
         pend_v_in = 1'b1;
         pend_in   = ctl.evt;
      end else if (ctl.flush && room) begin
         pend_v_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_v_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         pend_v_ff    <= pend_v_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      pend_ff <= pend_in;
      rsp_ff  <= rsp_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

endmodule

// File: test/key_event_checker.sv
`timescale 1ns / 1ps

module key_event_checker import hrke_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   input  logic    req_stall,
   input  req_type req_payload,
   input  logic    rsp_valid,
   input  logic    rsp_stall,
   input  rsp_type rsp_payload,
   output int      fail_count,
   output int      events_pending
);

   localparam int MAX_REPORT_EVENTS = MOD_BITS + 2 * SLOT_COUNT;

   logic [7:0]  code_map [MAP_DEPTH];
   logic [7:0]  press_count [COUNT_DEPTH];
   logic [7:0]  held_mods;
   key_set_type held_keys;
   rsp_type     expected_events [$];
   rsp_type     report_events [MAX_REPORT_EVENTS];
   int          staged_len;

   task automatic report_mismatch(input string msg);
      if (fail_count < 100) begin
         $display("%0t ns: mismatch: %s", $time, msg);
      end
      fail_count++;
   endtask

   function automatic logic key_listed(input key_set_type keys, input logic [7:0] usage);
      logic found;
      found = 1'b0;
      for (int i = 0; i < SLOT_COUNT; i++) begin
         if (keys[i] == usage) begin
            found = 1'b1;
         end
      end
      return found;
   endfunction

   // count update for one translated key, appends an event when one is due
   task automatic note_key(input logic press, input logic [7:0] code);
      if (code != 8'd0) begin
         if (press) begin
            if (press_count[code] == 8'd0) begin
               report_events[staged_len] = {1'b1, code, 1'b0};
               staged_len++;
            end
            if (press_count[code] != COUNT_MAX) begin
               press_count[code] = press_count[code] + 8'd1;
            end
         end else if (press_count[code] != 8'd0) begin
            press_count[code] = press_count[code] - 8'd1;
            if (press_count[code] == 8'd0) begin
               report_events[staged_len] = {1'b0, code, 1'b0};
               staged_len++;
            end
         end
      end
   endtask

   task automatic predict_report(input req_type item);
      key_set_type new_keys;
      new_keys = {item.key_slot_5, item.key_slot_4, item.key_slot_3,
                  item.key_slot_2, item.key_slot_1, item.key_slot_0};
      staged_len = 0;
      for (int i = 0; i < MOD_BITS; i++) begin
         if (held_mods[i] != item.modifier_bits[i]) begin
            note_key(item.modifier_bits[i], code_map[MOD_BASE + i]);
         end
      end
      for (int i = 0; i < SLOT_COUNT; i++) begin
         if (held_keys[i] != 8'd0 && !key_listed(new_keys, held_keys[i])) begin
            note_key(1'b0, code_map[held_keys[i]]);
         end
      end
      for (int i = 0; i < SLOT_COUNT; i++) begin
         if (new_keys[i] != 8'd0 && !key_listed(held_keys, new_keys[i])) begin
            note_key(1'b1, code_map[new_keys[i]]);
         end
      end
      held_keys = new_keys;
      held_mods = item.modifier_bits;
      for (int i = 0; i < staged_len; i++) begin
         if (i == staged_len - 1) begin
            report_events[i].last = 1'b1;
         end
         expected_events.push_back(report_events[i]);
      end
   endtask

   always @(posedge clock) begin : watch_channels
      rsp_type want;
      if (reset) begin
         held_mods = '0;
         held_keys = '0;
         expected_events.delete();
         for (int i = 0; i < MAP_DEPTH; i++) begin
            code_map[i] = 8'd0;
         end
         for (int i = 0; i < COUNT_DEPTH; i++) begin
            press_count[i] = 8'd0;
         end
      end else begin
         // an event leaving now cannot come from a request taken at this edge
         if (rsp_valid && !rsp_stall) begin
            if (expected_events.size() == 0) begin
               report_mismatch($sformatf("unexpected event pressed=%0d code=%02h last=%0d",
                  rsp_payload.pressed, rsp_payload.key_code, rsp_payload.last));
            end else begin
               want = expected_events.pop_front();
               if (rsp_payload.pressed !== want.pressed) begin
                  report_mismatch($sformatf("pressed got %0d expected %0d (code %02h)",
                     rsp_payload.pressed, want.pressed, want.key_code));
               end
               if (rsp_payload.key_code !== want.key_code) begin
                  report_mismatch($sformatf("key_code got %02h expected %02h",
                     rsp_payload.key_code, want.key_code));
               end
               if (rsp_payload.last !== want.last) begin
                  report_mismatch($sformatf("last got %0d expected %0d (code %02h)",
                     rsp_payload.last, want.last, want.key_code));
               end
            end
         end
         if (req_valid && !req_stall) begin
            case (req_payload.command)
               CMD_REPORT: begin
                  predict_report(req_payload);
               end
               CMD_MAP_WRITE: begin
                  if (req_payload.map_index < MAP_DEPTH) begin
                     code_map[req_payload.map_index] = req_payload.map_code;
                  end
               end
               CMD_RECONNECT: begin
                  held_mods = '0;
                  held_keys = '0;
               end
               default: begin
               end
            endcase
         end
      end
      events_pending = expected_events.size();
   end

endmodule

// File: test/testbench.sv
`timescale 1ns / 1ps

module testbench;
   import hrke_pkg::*;

   // quiet cycles allowed: covers the clearing pass after reset and a slow
   // report under heavy receiver stall, several times over
   localparam int WATCHDOG_LIMIT = 4000;
   // settle time after the last expected event, past the longest report walk
   localparam int DRAIN_CYCLES   = 200;
   localparam int RANDOM_ITEMS   = 270;
   localparam logic [1:0] CMD_UNUSED = 2'd3;

   logic    clock       = 1'b0;
   logic    reset       = 1'b1;
   logic    req_valid   = 1'b0;
   logic    req_stall;
   req_type req_payload = '0;
   logic    rsp_valid;
   logic    rsp_stall   = 1'b0;
   rsp_type rsp_payload;

   int fail_count;
   int events_pending;

   // idle percentages of the two sides, changed per phase
   int send_idle_pct = 0;
   int recv_idle_pct = 0;

   // report the stimulus last sent, so new reports grow out of the old one
   logic [7:0]  live_mods = '0;
   key_set_type live_keys = '0;

   hid_report_to_key_events_core dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

   key_event_checker events_check (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_payload    (req_payload),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_payload    (rsp_payload),
      .fail_count     (fail_count),
      .events_pending (events_pending)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // receiver back-pressure, random per cycle
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         rsp_stall <= ($urandom_range(99) < recv_idle_pct);
      end
   end

   // ends the run when no transaction moves on either channel for too long
   initial begin : watchdog
      int quiet;
      quiet = 0;
      while (quiet < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
            quiet = 0;
         end else begin
            quiet++;
         end
      end
      $display("TEST FAILED");
      $finish;
   end

   // usages mostly from a small pool so consecutive reports overlap
   function automatic logic [7:0] pick_usage();
      int r;
      r = $urandom_range(99);
      if (r < 65) begin
         return 8'($urandom_range(12, 1));
      end else if (r < 78) begin
         return 8'd0;
      end else if (r < 90) begin
         return 8'($urandom_range(255, 250));
      end
      return 8'($urandom_range(255));
   endfunction

   // codes mostly from a small pool so different keys share a press count
   function automatic logic [7:0] pick_code();
      int r;
      r = $urandom_range(99);
      if (r < 10) begin
         return 8'd0;
      end else if (r < 70) begin
         return 8'($urandom_range(16, 1));
      end else if (r < 78) begin
         return 8'hFF;
      end
      return 8'($urandom_range(255, 1));
   endfunction

   function automatic logic [8:0] pick_index();
      int r;
      r = $urandom_range(99);
      if (r < 50) begin
         return 9'($urandom_range(12));
      end else if (r < 62) begin
         return 9'($urandom_range(255, 250));
      end else if (r < 80) begin
         return 9'($urandom_range(MOD_BASE + MOD_BITS - 1, MOD_BASE));
      end else if (r < 92) begin
         return 9'($urandom_range(MAP_DEPTH - 1));
      end
      // beyond the map, must be dropped
      return 9'($urandom_range(511, MAP_DEPTH));
   endfunction

   // every field random; callers then set the fields the command uses
   function automatic req_type noise_item();
      req_type item;
      item.command       = 2'($urandom);
      item.modifier_bits = 8'($urandom);
      item.key_slot_0    = 8'($urandom);
      item.key_slot_1    = 8'($urandom);
      item.key_slot_2    = 8'($urandom);
      item.key_slot_3    = 8'($urandom);
      item.key_slot_4    = 8'($urandom);
      item.key_slot_5    = 8'($urandom);
      item.map_index     = 9'($urandom);
      item.map_code      = 8'($urandom);
      return item;
   endfunction

   function automatic key_set_type make_keys(input logic [7:0] k0, input logic [7:0] k1,
                                             input logic [7:0] k2, input logic [7:0] k3,
                                             input logic [7:0] k4, input logic [7:0] k5);
      return {k5, k4, k3, k2, k1, k0};
   endfunction

   // one request transaction; returns at the edge that takes it, valid still high
   task automatic send(input req_type item);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_payload <= item;
      do begin
         @(posedge clock);
      end while (req_stall !== 1'b0);
   endtask

   task automatic send_report(input logic [7:0] mods, input key_set_type keys);
      req_type item;
      item               = noise_item();
      item.command       = CMD_REPORT;
      item.modifier_bits = mods;
      item.key_slot_0    = keys[0];
      item.key_slot_1    = keys[1];
      item.key_slot_2    = keys[2];
      item.key_slot_3    = keys[3];
      item.key_slot_4    = keys[4];
      item.key_slot_5    = keys[5];
      send(item);
      live_mods = mods;
      live_keys = keys;
   endtask

   task automatic send_map(input logic [8:0] index, input logic [7:0] code);
      req_type item;
      item           = noise_item();
      item.command   = CMD_MAP_WRITE;
      item.map_index = index;
      item.map_code  = code;
      send(item);
   endtask

   task automatic send_command(input logic [1:0] command);
      req_type item;
      item         = noise_item();
      item.command = command;
      send(item);
   endtask

   // hold the sender off until every predicted event has left the block
   task automatic wait_drained();
      req_valid <= 1'b0;
      @(negedge clock);
      while (events_pending != 0) begin
         @(negedge clock);
      end
      @(posedge clock);
   endtask

   // mostly reports that change a little from the last one, some map writes,
   // reconnects, the unused command and a few reports of pure noise
   task automatic random_item();
      int          r;
      int          k;
      int          bit_pos;
      logic [7:0]  mods;
      key_set_type keys;
      r = $urandom_range(99);
      if (r < 68) begin
         mods = live_mods;
         keys = live_keys;
         k = $urandom_range(9);
         if (k < 5) begin
            bit_pos = $urandom_range(MOD_BITS - 1);
            mods[bit_pos] = ~mods[bit_pos];
         end else if (k < 7) begin
            mods = 8'($urandom);
         end
         for (int i = 0; i < SLOT_COUNT; i++) begin
            if ($urandom_range(3) == 0) begin
               keys[i] = pick_usage();
            end
         end
         send_report(mods, keys);
      end else if (r < 88) begin
         send_map(pick_index(), pick_code());
      end else if (r < 94) begin
         send_command(CMD_RECONNECT);
      end else if (r < 96) begin
         send_command(CMD_UNUSED);
      end else begin
         send_report(8'($urandom), make_keys(8'($urandom), 8'($urandom), 8'($urandom),
                                             8'($urandom), 8'($urandom), 8'($urandom)));
      end
   endtask

   // all fourteen sources share one code; reconnects keep re-pressing them
   // so the count climbs to its ceiling and saturates; only the first press makes an event
   task automatic saturate_code();
      logic [7:0]  code;
      key_set_type keys;
      code = 8'($urandom_range(255, 1));
      for (int i = 0; i < MOD_BITS; i++) begin
         send_map(9'(MOD_BASE + i), code);
      end
      for (int i = 0; i < SLOT_COUNT; i++) begin
         keys[i] = 8'(200 + i);
         send_map(9'(200 + i), code);
      end
      repeat (20) begin
         send_command(CMD_RECONNECT);
         send_report(8'hFF, keys);
      end
      send_report(8'h00, '0);
   endtask

   initial begin : stimulus
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // empty map: nothing comes out
      send_report(8'hFF, make_keys(8'd1, 8'd2, 8'd3, 8'd4, 8'd5, 8'd6));
      send_report(8'h00, '0);
      // writes past the end of the map are dropped
      send_map(9'd264, 8'h33);
      send_map(9'd511, 8'h44);
      send_map(9'(MOD_BASE), 8'h01);
      send_map(9'(MOD_BASE + MOD_BITS - 1), 8'hFF);
      // two usages share one code
      send_map(9'd4, 8'h10);
      send_map(9'd5, 8'h10);
      send_map(9'd255, 8'hFE);
      // usage zero means an empty slot, its map entry never matters
      send_map(9'd0, 8'h20);
      // all modifiers, shared code pressed once, a usage mapped to ignore
      send_report(8'hFF, make_keys(8'd4, 8'd5, 8'd255, 8'd6, 8'd0, 8'd0));
      // shared code still held by the repeated usage, no release yet
      send_report(8'h00, make_keys(8'd5, 8'd5, 8'd0, 8'd0, 8'd0, 8'd0));
      // usage in two slots: first slot releases, second finds the count at zero
      send_report(8'h00, '0);
      send_report(8'h81, make_keys(8'd255, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0));
      // reconnect forgets the held report but not the counts
      send_command(CMD_RECONNECT);
      send_report(8'h81, make_keys(8'd255, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0));
      send_report(8'h00, '0);
      send_command(CMD_UNUSED);
      send_report(8'h81, make_keys(8'd255, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0));
      // remap to ignore while held: release of that usage is dropped
      send_map(9'd255, 8'h00);
      send_report(8'h00, '0);
      send_report(8'h00, '0);
      wait_drained();

      for (int phase = 0; phase < 3; phase++) begin
         case (phase)
            0: begin
               send_idle_pct = 33;
               recv_idle_pct = 50;
            end
            1: begin
               send_idle_pct = 50;
               recv_idle_pct = 33;
            end
            default: begin
               send_idle_pct = 0;
               recv_idle_pct = 0;
            end
         endcase
         if (phase == 1) begin
            saturate_code();
         end
         for (int n = 0; n < RANDOM_ITEMS / 3; n++) begin
            if (n == RANDOM_ITEMS / 6) begin
               wait_drained();
            end
            random_item();
         end
      end

      wait_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);
      @(negedge clock);
      if (fail_count == 0 && events_pending == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
